>>> src/sbct_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the study/break cycle timer.
// Depends on nothing; used by sbct_fsm and study_break_cycle_timer_top.
package sbct_pkg;

    // Event codes carried with every request
    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_OK   = 3'd1;
    localparam logic [2:0] OP_UP   = 3'd2;
    localparam logic [2:0] OP_DOWN = 3'd3;
    localparam logic [2:0] OP_SKIP = 3'd4;

    // Alert codes reported with a result
    localparam logic [1:0] ALERT_NONE    = 2'd0;
    localparam logic [1:0] ALERT_STUDY   = 2'd1;
    localparam logic [1:0] ALERT_BREAK   = 2'd2;
    localparam logic [1:0] ALERT_SUMMARY = 2'd3;

    // External stage numbering
    localparam logic [2:0] CODE_IDLE       = 3'd0;
    localparam logic [2:0] CODE_SET_STUDY  = 3'd1;
    localparam logic [2:0] CODE_SET_BREAK  = 3'd2;
    localparam logic [2:0] CODE_SET_ROUNDS = 3'd3;
    localparam logic [2:0] CODE_STUDY      = 3'd4;
    localparam logic [2:0] CODE_BREAK      = 3'd5;
    localparam logic [2:0] CODE_SUMMARY    = 3'd6;

    // Limits and reset values of the settings
    localparam logic [2:0] MAX_ROUNDS    = 3'd5;
    localparam logic [2:0] RESET_ROUNDS  = 3'd2;
    localparam logic [6:0] RESET_STUDY   = 7'd45;
    localparam logic [5:0] RESET_BREAK   = 6'd15;
    localparam logic [7:0] STUDY_MIN     = 8'd5;
    localparam logic [7:0] STUDY_MAX     = 8'd120;
    localparam logic [7:0] STUDY_UP_BIG  = 8'd60;
    localparam logic [7:0] STUDY_DN_BIG  = 8'd70;
    localparam logic [7:0] STUDY_STEP_LO = 8'd5;
    localparam logic [7:0] STUDY_STEP_HI = 8'd10;
    localparam logic [6:0] BREAK_MIN     = 7'd1;
    localparam logic [6:0] BREAK_MAX     = 7'd60;
    localparam logic [6:0] BREAK_UP_BIG  = 7'd10;
    localparam logic [6:0] BREAK_DN_BIG  = 7'd15;
    localparam logic [6:0] BREAK_STEP_LO = 7'd1;
    localparam logic [6:0] BREAK_STEP_HI = 7'd5;

    // Timing constants in seconds
    localparam logic [32:0] GUARD_SECONDS   = 33'd2;
    localparam logic [32:0] SUMMARY_SECONDS = 33'd60;

    // Reciprocal of 60 scaled by 2^19, exact for dividends below 7200
    localparam logic [13:0] RECIP_60   = 14'd8739;
    localparam int          RECIP_SHIFT = 19;

    // One-hot stage register
    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_SET_STUDY  = 7'b0000010,
        ST_SET_BREAK  = 7'b0000100,
        ST_SET_ROUNDS = 7'b0001000,
        ST_STUDY      = 7'b0010000,
        ST_BREAK      = 7'b0100000,
        ST_SUMMARY    = 7'b1000000
    } t_stage;

    // One result item as produced by the state update
    typedef struct packed {
        logic [2:0] stage;
        logic [2:0] round_index;
        logic [2:0] round_total;
        logic [6:0] study_length;
        logic [5:0] break_length;
        logic [6:0] elapsed_minutes;
        logic [1:0] alert_pattern;
        logic       confirm_request;
        logic       key_handled;
    } t_result;

    // Map the one-hot stage onto its external number
    function automatic logic [2:0] stage_code(input t_stage st);
        logic [2:0] code;
        unique case (st)
            ST_IDLE:       code = CODE_IDLE;
            ST_SET_STUDY:  code = CODE_SET_STUDY;
            ST_SET_BREAK:  code = CODE_SET_BREAK;
            ST_SET_ROUNDS: code = CODE_SET_ROUNDS;
            ST_STUDY:      code = CODE_STUDY;
            ST_BREAK:      code = CODE_BREAK;
            ST_SUMMARY:    code = CODE_SUMMARY;
            default:       code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

>>> src/sbct_fsm.sv
`timescale 1ns / 1ps
// Stage sequencer, settings registers and result formation of the timer.
// Depends on sbct_pkg; instantiated by study_break_cycle_timer_top.
module sbct_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [2:0]       i_opcode,
    input  logic [31:0]      i_now,
    output sbct_pkg::t_result o_result
);

    sbct_pkg::t_stage r_stage, n_stage;
    logic [2:0]  r_round, n_round;
    logic [2:0]  r_rounds, n_rounds;
    logic [6:0]  r_study, n_study;
    logic [5:0]  r_break, n_break;
    logic [31:0] r_start, n_start;

    logic        do_adv;
    logic [1:0]  alert;
    logic        confirm;
    logic        handled;
    logic        in_phase;
    logic [32:0] now_ext;
    logic [32:0] start_ext;
    logic [12:0] study_sec;
    logic [12:0] break_sec;
    logic        study_due;
    logic        break_due;
    logic        summary_due;
    logic [7:0]  study_step;
    logic [7:0]  study_adj;
    logic [6:0]  break_step;
    logic [6:0]  break_adj;

    logic [6:0]  len;
    logic [12:0] len_sec;
    logic [31:0] diff;
    logic [26:0] prod;
    logic [6:0]  elapsed;

    // Phase lengths in seconds and the expiry checks, all without wrap
    always_comb begin
        now_ext     = {1'b0, i_now};
        start_ext   = {1'b0, r_start};
        study_sec   = {r_study, 6'b0} - {4'b0, r_study, 2'b0};
        break_sec   = {1'b0, r_break, 6'b0} - {5'b0, r_break, 2'b0};
        study_due   = (now_ext + sbct_pkg::GUARD_SECONDS) >= (start_ext + {20'b0, study_sec});
        break_due   = (now_ext + sbct_pkg::GUARD_SECONDS) >= (start_ext + {20'b0, break_sec});
        summary_due = now_ext >= (start_ext + sbct_pkg::SUMMARY_SECONDS);
        in_phase    = (r_stage == sbct_pkg::ST_STUDY) || (r_stage == sbct_pkg::ST_BREAK);
    end

    // Saturating adjustment of the study and break lengths
    always_comb begin
        if (i_opcode == sbct_pkg::OP_UP) begin
            study_step = ({1'b0, r_study} >= sbct_pkg::STUDY_UP_BIG) ?
                         sbct_pkg::STUDY_STEP_HI : sbct_pkg::STUDY_STEP_LO;
            study_adj  = ({1'b0, r_study} + study_step > sbct_pkg::STUDY_MAX) ?
                         sbct_pkg::STUDY_MAX : {1'b0, r_study} + study_step;
            break_step = ({1'b0, r_break} >= sbct_pkg::BREAK_UP_BIG) ?
                         sbct_pkg::BREAK_STEP_HI : sbct_pkg::BREAK_STEP_LO;
            break_adj  = ({1'b0, r_break} + break_step > sbct_pkg::BREAK_MAX) ?
                         sbct_pkg::BREAK_MAX : {1'b0, r_break} + break_step;
        end else begin
            study_step = ({1'b0, r_study} >= sbct_pkg::STUDY_DN_BIG) ?
                         sbct_pkg::STUDY_STEP_HI : sbct_pkg::STUDY_STEP_LO;
            study_adj  = ({1'b0, r_study} >= sbct_pkg::STUDY_MIN + study_step) ?
                         {1'b0, r_study} - study_step : sbct_pkg::STUDY_MIN;
            break_step = ({1'b0, r_break} >= sbct_pkg::BREAK_DN_BIG) ?
                         sbct_pkg::BREAK_STEP_HI : sbct_pkg::BREAK_STEP_LO;
            break_adj  = ({1'b0, r_break} >= sbct_pkg::BREAK_MIN + break_step) ?
                         {1'b0, r_break} - break_step : sbct_pkg::BREAK_MIN;
        end
    end

    // Event decode and stage transitions
    always_comb begin
        n_stage  = r_stage;
        n_round  = r_round;
        n_rounds = r_rounds;
        n_study  = r_study;
        n_break  = r_break;
        n_start  = r_start;
        do_adv   = 1'b0;
        alert    = sbct_pkg::ALERT_NONE;
        confirm  = 1'b0;
        handled  = 1'b0;

        unique case (i_opcode) inside
            sbct_pkg::OP_TICK: begin
                if (r_stage == sbct_pkg::ST_STUDY) begin
                    do_adv = study_due;
                end else if (r_stage == sbct_pkg::ST_BREAK) begin
                    do_adv = break_due;
                end else if (r_stage == sbct_pkg::ST_SUMMARY) begin
                    do_adv = summary_due;
                end
            end
            sbct_pkg::OP_OK: begin
                handled = 1'b1;
                if (in_phase) begin
                    confirm = 1'b1;
                end else begin
                    do_adv = 1'b1;
                end
            end
            sbct_pkg::OP_UP, sbct_pkg::OP_DOWN: begin
                handled = 1'b1;
                if (r_stage == sbct_pkg::ST_SET_STUDY) begin
                    n_study = study_adj[6:0];
                end else if (r_stage == sbct_pkg::ST_SET_BREAK) begin
                    n_break = break_adj[5:0];
                end else if (r_stage == sbct_pkg::ST_SET_ROUNDS) begin
                    if (i_opcode == sbct_pkg::OP_UP) begin
                        if (r_rounds < sbct_pkg::MAX_ROUNDS) begin
                            n_rounds = r_rounds + 3'd1;
                        end
                    end else if (r_rounds > 3'd1) begin
                        n_rounds = r_rounds - 3'd1;
                    end
                end
            end
            sbct_pkg::OP_SKIP: begin
                do_adv = in_phase;
            end
            default: begin
            end
        endcase

        // Moving on to the next stage
        if (do_adv) begin
            unique case (r_stage)
                sbct_pkg::ST_IDLE:      n_stage = sbct_pkg::ST_SET_STUDY;
                sbct_pkg::ST_SET_STUDY: n_stage = sbct_pkg::ST_SET_BREAK;
                sbct_pkg::ST_SET_BREAK: n_stage = sbct_pkg::ST_SET_ROUNDS;
                sbct_pkg::ST_SET_ROUNDS: begin
                    n_stage = sbct_pkg::ST_STUDY;
                    n_round = 3'd1;
                    n_start = i_now;
                    alert   = sbct_pkg::ALERT_STUDY;
                end
                sbct_pkg::ST_STUDY: begin
                    n_stage = sbct_pkg::ST_BREAK;
                    n_start = i_now;
                    alert   = sbct_pkg::ALERT_BREAK;
                end
                sbct_pkg::ST_BREAK: begin
                    n_start = i_now;
                    if (r_round < r_rounds) begin
                        n_stage = sbct_pkg::ST_STUDY;
                        n_round = r_round + 3'd1;
                        alert   = sbct_pkg::ALERT_STUDY;
                    end else begin
                        n_stage = sbct_pkg::ST_SUMMARY;
                        alert   = sbct_pkg::ALERT_SUMMARY;
                    end
                end
                sbct_pkg::ST_SUMMARY: begin
                    n_stage = sbct_pkg::ST_IDLE;
                    n_round = 3'd1;
                end
                default: begin
                end
            endcase
        end
    end

    // Whole minutes into the phase after the update, capped at its length.
    // Below the cap the difference is under 7200 s, so a reciprocal multiply
    // gives the exact quotient by 60.
    always_comb begin
        len     = (n_stage == sbct_pkg::ST_STUDY) ? n_study : {1'b0, n_break};
        len_sec = {len, 6'b0} - {4'b0, len, 2'b0};
        diff    = i_now - n_start;
        prod    = diff[12:0] * sbct_pkg::RECIP_60;
        elapsed = 7'd0;
        if ((n_stage == sbct_pkg::ST_STUDY || n_stage == sbct_pkg::ST_BREAK)
            && (i_now >= n_start)) begin
            if (diff >= {19'b0, len_sec}) begin
                elapsed = len;
            end else begin
                elapsed = prod[sbct_pkg::RECIP_SHIFT +: 7];
            end
        end
    end

    // State registers, updated once per processed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage  <= sbct_pkg::ST_IDLE;
            r_round  <= 3'd1;
            r_rounds <= sbct_pkg::RESET_ROUNDS;
            r_study  <= sbct_pkg::RESET_STUDY;
            r_break  <= sbct_pkg::RESET_BREAK;
            r_start  <= 32'd0;
        end else if (i_en) begin
            r_stage  <= n_stage;
            r_round  <= n_round;
            r_rounds <= n_rounds;
            r_study  <= n_study;
            r_break  <= n_break;
            r_start  <= n_start;
        end
    end

    // Result of this request, taken after the update
    always_comb begin
        o_result.stage           = sbct_pkg::stage_code(n_stage);
        o_result.round_index     = n_round;
        o_result.round_total     = n_rounds;
        o_result.study_length    = n_study;
        o_result.break_length    = n_break;
        o_result.elapsed_minutes = elapsed;
        o_result.alert_pattern   = alert;
        o_result.confirm_request = confirm;
        o_result.key_handled     = handled;
    end

endmodule

>>> src/study_break_cycle_timer_top.sv
`timescale 1ns / 1ps
// Top level of the study/break cycle timer: input register, result register
// and stream handshakes. Depends on sbct_pkg and sbct_fsm.
//
// Usage: each request on the slave stream is one event. i_s_tuser carries the
// event code (tick, ok, up, down, skip confirmed) and i_s_tdata the current
// real-time clock in seconds. Every request yields exactly one result on the
// master stream, in order, holding the stage, round, settings, minutes into
// the phase, the alert raised and the ok/confirm flags.
// Path: a request is taken into the input register, processed from there into the
// result register once that register can take it, and its result is offered on
// the master stream from then on.
// Throughput: one request per cycle while the master stream takes results, set by
// the state update between the input register and the result register.
// Stall: while the result register is full and i_m_tready is low, the input
// register still takes one further request; o_s_tready then drops until the
// result is taken. Nothing is lost or repeated.
// Reset (i_rst_n low, synchronous): both registers empty, stage idle, round 1,
// study 45 min, break 15 min, two rounds, phase start 0. o_s_tready is held
// low while reset is applied, so no request is taken then.
module study_break_cycle_timer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] now_seconds
    input  logic [7:0]  i_s_tuser,   // [2:0] opcode, [7:3] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [2:0] stage, [5:3] round_index, [8:6] round_total, [15:9] study_length,
    // [21:16] break_length, [28:22] elapsed_minutes, [30:29] alert_pattern,
    // [31] confirm_request, [32] key_handled, [39:33] zero
    output logic [39:0] o_m_tdata
);

    logic        r_in_valid;
    logic [2:0]  r_opcode;
    logic [31:0] r_now;
    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic        proceed;
    logic        process;
    sbct_pkg::t_result result;

    // The input register moves on whenever the result register can take
    assign proceed    = !r_out_valid || i_m_tready;
    assign process    = r_in_valid && proceed;
    assign o_s_tready = i_rst_n && (!r_in_valid || proceed);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_opcode <= i_s_tuser[2:0];
            r_now    <= i_s_tdata;
        end
    end

    // State update for the request in the input register
    sbct_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (process),
        .i_opcode (r_opcode),
        .i_now    (r_now),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_data <= {7'b0,
                           result.key_handled,
                           result.confirm_request,
                           result.alert_pattern,
                           result.elapsed_minutes,
                           result.break_length,
                           result.study_length,
                           result.round_total,
                           result.round_index,
                           result.stage};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
